FILE: rtl/atbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert tone burst generator package
// Shared types, register indexes, reset values and the sine ROM builder.
// ----------------------------------------------------------------------------
package atbg_pkg;

   // Configuration port.
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 31;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEEP_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_COUNT = 3'd4;

   localparam logic [3:0]  VOLUME_RESET      = 4'd7;
   localparam logic [30:0] PHASE_STEP_RESET  = 31'd85704563;
   localparam logic [15:0] BEEP_LENGTH_RESET = 16'd13230;
   localparam logic [15:0] GAP_LENGTH_RESET  = 16'd8820;
   localparam logic [3:0]  PULSE_COUNT_RESET = 4'd3;

   // Amplitude per volume step.
   localparam logic [11:0] TONE_GAIN = 12'd2800;

   // Pi/2 in Q30.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Envelope classes.
   localparam logic [1:0] ENV_ZERO = 2'd0;
   localparam logic [1:0] ENV_ONE  = 2'd1;
   localparam logic [1:0] ENV_DIV  = 2'd2;

   typedef struct packed {
      logic start;
      logic setup;
      logic div_step;
      logic mul_gain;
      logic mul_env;
      logic finish;
   } atbg_cmd_type;

   typedef struct packed {
      logic need_div;
   } atbg_sts_type;

   // Quarter-wave sine magnitude in Q15 at position q of 2**qbits, from a
   // Taylor series in Q30. Evaluated at elaboration only.
   function automatic logic [14:0] quarter_sine(input int unsigned q,
                                                input int unsigned qbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      x    = (64'(q) * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/atbg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert tone burst generator controller
// Sequences setup, envelope division, the two multiplies and result hand-off.
// ----------------------------------------------------------------------------
module atbg_ctrl #(
   parameter int unsigned ENVELOPE_FRACTION_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output atbg_pkg::atbg_cmd_type      cmd,
   input  wire atbg_pkg::atbg_sts_type sts
);
   import atbg_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(ENVELOPE_FRACTION_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ENVELOPE_FRACTION_BITS - 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SETUP    = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_MUL_GAIN = 3'd3;
   localparam logic [2:0] S_MUL_ENV  = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = sts.need_div ? S_DIV : S_MUL_GAIN;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MUL_GAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = S_MUL_ENV;
         end
         S_MUL_ENV: begin
            cmd.mul_env = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_SETUP))
      else $error("accepted request did not enter setup");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CNT_LAST) |=> (state_ff == S_MUL_GAIN))
      else $error("divider did not stop after the last quotient bit");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished request not presented");

endmodule
`default_nettype wire

FILE: rtl/atbg_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert tone burst generator datapath
// Settings, alert position, sine ROM, envelope divider, multiplies, output.
// ----------------------------------------------------------------------------
module atbg_dpath #(
   parameter int unsigned SINE_INDEX_BITS        = 10,
   parameter int unsigned ENVELOPE_FRACTION_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire atbg_pkg::atbg_cmd_type                 cmd,
   output atbg_pkg::atbg_sts_type                      sts,
   input  wire logic                                   req_trigger,
   input  wire logic                                   csr_write,
   input  wire logic [atbg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [atbg_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output logic signed [15:0]                          rsp_sample,
   output logic                                        rsp_playing,
   output logic                                        rsp_last
);
   import atbg_pkg::*;

   localparam int unsigned SIB       = SINE_INDEX_BITS;
   localparam int unsigned FB        = ENVELOPE_FRACTION_BITS;
   localparam int unsigned QBITS     = SIB - 2;
   localparam int unsigned QUARTER   = 1 << QBITS;
   localparam int unsigned ENV_BITS  = FB + 1;
   localparam int unsigned GM_BITS   = 31;
   localparam int unsigned PROD_BITS = FB + 32;

   // Settings.
   logic [3:0]  volume_ff, volume_in;
   logic [30:0] phase_step_ff, phase_step_in;
   logic [15:0] beep_length_ff, beep_length_in;
   logic [15:0] gap_length_ff, gap_length_in;
   logic [3:0]  pulse_count_ff, pulse_count_in;

   // Alert position.
   logic [31:0] phase_ff, phase_in;
   logic [15:0] seg_ff, seg_in;
   logic        in_gap_ff, in_gap_in;
   logic [3:0]  pidx_ff, pidx_in;
   logic        active_ff, active_in;

   // Per-sample working registers.
   logic [1:0]           cls_ff, cls_in;
   logic [15:0]          rem_ff, rem_in;
   logic [FB-1:0]        quo_ff, quo_in;
   logic [14:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [15:0]          gain_ff, gain_in;
   logic [GM_BITS-1:0]   gm_ff, gm_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   // Output register.
   logic [15:0] sample_ff, sample_in;
   logic        playing_ff, playing_in;
   logic        last_ff, last_in;

   // Quarter-wave sine ROM, built at elaboration.
   logic [14:0] qtab [QUARTER+1];
   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      localparam logic [14:0] QVAL = quarter_sine(k, QBITS);
      assign qtab[k] = QVAL;
   end

   logic [15:0]    len;
   logic [3:0]     pulses;
   logic [12:0]    len_eighth;
   logic [18:0]    len_x7;
   logic [15:0]    seven_eighths;
   logic [15:0]    num;
   logic [1:0]     cls;
   logic [SIB-1:0] rom_idx;
   logic [1:0]     quad;
   logic [QBITS:0] rom_addr;
   logic [16:0]    div_t;
   logic [ENV_BITS-1:0] env;
   logic [16:0]    mag_q;
   logic [15:0]    sat;
   logic [16:0]    seg_inc;
   logic           next_pulse;
   logic           fin;

   assign len    = (beep_length_ff != '0) ? beep_length_ff : 16'd1;
   assign pulses = (pulse_count_ff != '0) ? pulse_count_ff : 4'd1;

   // Envelope class: rising ramp, flat top, falling ramp or silent.
   assign len_eighth    = len[15:3];
   assign len_x7        = {len, 3'b000} - {3'b000, len};
   assign seven_eighths = len_x7[18:3];

   always_comb begin
      num = '0;
      if (!active_ff || in_gap_ff || seg_ff >= len) begin
         cls = ENV_ZERO;
      end else if (seg_ff < {3'b000, len_eighth}) begin
         cls = ENV_DIV;
         num = seg_ff;
      end else if (seg_ff > seven_eighths) begin
         cls = ENV_DIV;
         num = len - seg_ff;
      end else begin
         cls = ENV_ONE;
      end
   end

   assign sts.need_div = (cls == ENV_DIV);

   // Full wave from the quarter table by mirroring and sign.
   assign rom_idx  = phase_ff[31 -: SIB];
   assign quad     = rom_idx[SIB-1 -: 2];
   assign rom_addr = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, rom_idx[QBITS-1:0]})
                             : {1'b0, rom_idx[QBITS-1:0]};

   assign div_t = {rem_ff, 1'b0};

   always_comb begin
      case (cls_ff)
         ENV_ZERO: env = '0;
         ENV_ONE:  env = ENV_BITS'(1) << FB;
         ENV_DIV:  env = {1'b0, quo_ff};
         default:  env = '0;
      endcase
   end

   // Scale down and saturate.
   assign mag_q = prod_ff[PROD_BITS-1 -: 17];
   always_comb begin
      if (neg_ff) begin
         sat = (mag_q > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag_q);
      end else begin
         sat = (mag_q > 17'd32767) ? 16'h7FFF : mag_q[15:0];
      end
   end

   always_comb begin
      volume_in      = volume_ff;
      phase_step_in  = phase_step_ff;
      beep_length_in = beep_length_ff;
      gap_length_in  = gap_length_ff;
      pulse_count_in = pulse_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_VOLUME:      volume_in      = csr_data[3:0];
            CSR_PHASE_STEP:  phase_step_in  = csr_data[30:0];
            CSR_BEEP_LENGTH: beep_length_in = csr_data[15:0];
            CSR_GAP_LENGTH:  gap_length_in  = csr_data[15:0];
            CSR_PULSE_COUNT: pulse_count_in = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      seg_in     = seg_ff;
      in_gap_in  = in_gap_ff;
      pidx_in    = pidx_ff;
      active_in  = active_ff;
      next_pulse = 1'b0;
      fin        = 1'b0;
      seg_inc    = {1'b0, seg_ff} + 17'd1;
      if (cmd.start && req_trigger) begin
         active_in = 1'b1;
         pidx_in   = '0;
         in_gap_in = 1'b0;
         seg_in    = '0;
         phase_in  = '0;
      end
      if (cmd.finish && active_ff) begin
         if (!in_gap_ff) begin
            phase_in = phase_ff + {1'b0, phase_step_ff};
            if (seg_inc >= {1'b0, len}) begin
               seg_in = '0;
               if (gap_length_ff != '0) begin
                  in_gap_in = 1'b1;
               end else begin
                  next_pulse = 1'b1;
               end
            end else begin
               seg_in = seg_inc[15:0];
            end
         end else begin
            if (seg_inc >= {1'b0, gap_length_ff}) begin
               next_pulse = 1'b1;
            end else begin
               seg_in = seg_inc[15:0];
            end
         end
         if (next_pulse) begin
            if ({1'b0, pidx_ff} + 5'd1 >= {1'b0, pulses}) begin
               fin       = 1'b1;
               active_in = 1'b0;
               pidx_in   = '0;
            end else begin
               pidx_in = pidx_ff + 4'd1;
            end
            seg_in    = '0;
            in_gap_in = 1'b0;
            phase_in  = '0;
         end
      end
   end

   always_comb begin
      cls_in     = cls_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      gain_in    = gain_ff;
      gm_in      = gm_ff;
      prod_in    = prod_ff;
      sample_in  = sample_ff;
      playing_in = playing_ff;
      last_in    = last_ff;
      if (cmd.setup) begin
         cls_in  = cls;
         rem_in  = {num[12:0], 3'b000};
         quo_in  = '0;
         mag_in  = qtab[rom_addr];
         neg_in  = quad[1];
         gain_in = {4'b0000, TONE_GAIN} * {12'd0, volume_ff};
      end
      if (cmd.div_step) begin
         if (div_t >= {1'b0, len}) begin
            rem_in = 16'(div_t - {1'b0, len});
            quo_in = {quo_ff[FB-2:0], 1'b1};
         end else begin
            rem_in = div_t[15:0];
            quo_in = {quo_ff[FB-2:0], 1'b0};
         end
      end
      if (cmd.mul_gain) begin
         gm_in = GM_BITS'(gain_ff) * GM_BITS'(mag_ff);
      end
      if (cmd.mul_env) begin
         prod_in = PROD_BITS'(gm_ff) * PROD_BITS'(env);
      end
      if (cmd.finish) begin
         sample_in  = active_ff ? sat : 16'd0;
         playing_in = active_ff;
         last_in    = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff      <= VOLUME_RESET;
         phase_step_ff  <= PHASE_STEP_RESET;
         beep_length_ff <= BEEP_LENGTH_RESET;
         gap_length_ff  <= GAP_LENGTH_RESET;
         pulse_count_ff <= PULSE_COUNT_RESET;
         phase_ff       <= '0;
         seg_ff         <= '0;
         in_gap_ff      <= 1'b0;
         pidx_ff        <= '0;
         active_ff      <= 1'b0;
         playing_ff     <= 1'b0;
         last_ff        <= 1'b0;
         sample_ff      <= '0;
      end else begin
         volume_ff      <= volume_in;
         phase_step_ff  <= phase_step_in;
         beep_length_ff <= beep_length_in;
         gap_length_ff  <= gap_length_in;
         pulse_count_ff <= pulse_count_in;
         phase_ff       <= phase_in;
         seg_ff         <= seg_in;
         in_gap_ff      <= in_gap_in;
         pidx_ff        <= pidx_in;
         active_ff      <= active_in;
         playing_ff     <= playing_in;
         last_ff        <= last_in;
         sample_ff      <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff  <= cls_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      gain_ff <= gain_in;
      gm_ff   <= gm_in;
      prod_ff <= prod_in;
   end

   assign rsp_sample  = sample_ff;
   assign rsp_playing = playing_ff;
   assign rsp_last    = last_ff;

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      !playing_ff |-> (sample_ff == 16'd0 && !last_ff))
      else $error("idle sample is not silent");

   a_gap_in_alert: assert property (@(posedge clock) disable iff (reset)
      in_gap_ff |-> active_ff)
      else $error("gap flagged outside an alert");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      pidx_ff != 4'hF)
      else $error("pulse index ran past the largest pulse count");

endmodule
`default_nettype wire

FILE: rtl/alert_tone_burst_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert tone burst generator
// Produces one signed 16-bit audio sample per request; a trigger starts an
// alert of enveloped sine pulses separated by silent gaps.
// ----------------------------------------------------------------------------
// Usage: present one request per audio sample tick on req_valid/req_trigger.
// A request is taken when req_valid is high and req_stall is low; each one
// returns exactly one response (rsp_sample, rsp_playing, rsp_last) on the
// rsp_ channel, taken when rsp_valid is high and rsp_stall is low.
// Requests are handled one at a time. A sample on the rising or falling
// ramp of a pulse passes through the one-bit-per-cycle envelope divider
// before the next request can be taken; all other samples skip it. The
// steps are setup, divide (ramp samples only), gain multiply, envelope
// multiply and finish; rsp_valid is registered and rises as the finish
// step ends. A finished response sits in an output register, so a new
// request is taken while it waits; when the receiver stalls, the block
// holds the response and pauses before loading the next one.
// Reset returns the alert to idle and loads the default settings: volume 7,
// an 880 Hz step at 44.1 kHz, 13230-sample pulses, 8820-sample gaps and
// three pulses. Settings are written through csr_write/csr_index/csr_data.
// ----------------------------------------------------------------------------
module alert_tone_burst_generator #(
   parameter int unsigned SINE_INDEX_BITS        = 10,
   parameter int unsigned ENVELOPE_FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_trigger,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [15:0]                       rsp_sample,
   output logic                                     rsp_playing,
   output logic                                     rsp_last,
   input  wire logic                                csr_write,
   input  wire logic [atbg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [atbg_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import atbg_pkg::*;

   // Command and status between the sequencer and the arithmetic.
   atbg_cmd_type cmd;
   atbg_sts_type sts;

   // The controller owns the handshakes and the step sequence.
   atbg_ctrl #(
      .ENVELOPE_FRACTION_BITS(ENVELOPE_FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds settings, alert position and the sample pipeline.
   atbg_dpath #(
      .SINE_INDEX_BITS        (SINE_INDEX_BITS),
      .ENVELOPE_FRACTION_BITS (ENVELOPE_FRACTION_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_trigger (req_trigger),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_sample  (rsp_sample),
      .rsp_playing (rsp_playing),
      .rsp_last    (rsp_last)
   );

endmodule
`default_nettype wire

FILE: dv/alert_tone_burst_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alert tone burst generator testbench
// Sends sample-tick requests and register writes to the generator. An
// independent model of the pulse sequencer, trapezoid envelope and sine ROM
// predicts every response, and each response is compared as it is taken.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic signed [15:0] sample;
   logic               playing;
   logic               last;
} tone_result_type;

class alert_tone_checker;
   localparam int unsigned ROM_BITS = 10;
   localparam int unsigned ENV_BITS = 16;
   localparam int unsigned QUARTER = 1 << (ROM_BITS - 2);
   localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
   localparam longint unsigned GAIN_PER_STEP = 64'd2800;

   logic signed [15:0] sine_rom [1 << ROM_BITS];

   logic [3:0]  volume;
   logic [30:0] phase_step;
   logic [15:0] beep_length;
   logic [15:0] gap_length;
   logic [3:0]  pulse_count;

   logic [31:0] tone_phase;
   int unsigned seg_pos;
   bit          in_gap;
   int unsigned pulse_no;
   bit          alert_on;

   tone_result_type expected_samples[$];
   int unsigned     mismatches;
   int unsigned     checked;

   function new();
      int unsigned quadrant;
      int unsigned offset;
      int          level;
      for (int k = 0; k < (1 << ROM_BITS); k++) begin
         quadrant = k >> (ROM_BITS - 2);
         offset   = k % QUARTER;
         level    = quadrant[0] ? quarter_wave(QUARTER - offset) : quarter_wave(offset);
         sine_rom[k] = 16'(quadrant[1] ? -level : level);
      end
      volume      = atbg_pkg::VOLUME_RESET;
      phase_step  = atbg_pkg::PHASE_STEP_RESET;
      beep_length = atbg_pkg::BEEP_LENGTH_RESET;
      gap_length  = atbg_pkg::GAP_LENGTH_RESET;
      pulse_count = atbg_pkg::PULSE_COUNT_RESET;
      tone_phase  = '0;
      seg_pos     = 0;
      in_gap      = 1'b0;
      pulse_no    = 0;
      alert_on    = 1'b0;
      mismatches  = 0;
      checked     = 0;
   endfunction

   // Q15 sine of the first quadrant from a Q30 Taylor series, rounded half up.
   function int quarter_wave(int unsigned pos);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned rounded;
      longint          series;
      angle    = (64'(pos) * RIGHT_ANGLE_Q30) / QUARTER;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      series   = longint'(angle);
      for (int n = 1; n <= 6; n++) begin
         term = (term * angle_sq) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            series = series - longint'(term);
         end else begin
            series = series + longint'(term);
         end
      end
      if (series < 0) begin
         series = 0;
      end
      rounded = (64'(series) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return int'(rounded);
   endfunction

   function longint unsigned envelope_level(longint unsigned pos, longint unsigned span);
      if (pos >= span) begin
         return 0;
      end
      if (pos < span / 8) begin
         return ((64'd8 * pos) << ENV_BITS) / span;
      end
      if (pos > (span * 7) / 8) begin
         return ((64'd8 * (span - pos)) << ENV_BITS) / span;
      end
      return 64'd1 << ENV_BITS;
   endfunction

   function logic signed [15:0] shaped_tone(longint unsigned span);
      int              level;
      longint unsigned magnitude;
      longint unsigned product;
      longint unsigned scaled;
      level     = sine_rom[tone_phase[31 -: ROM_BITS]];
      magnitude = (level < 0) ? 64'(-level) : 64'(level);
      product   = GAIN_PER_STEP * volume * envelope_level(seg_pos, span) * magnitude;
      scaled    = product >> (ENV_BITS + 15);
      if (level < 0) begin
         return (scaled > 64'd32768) ? 16'sh8000 : 16'(64'd0 - scaled);
      end
      return (scaled > 64'd32767) ? 16'sh7fff : 16'(scaled);
   endfunction

   function tone_result_type next_sample(logic trigger);
      tone_result_type outcome;
      longint unsigned span;
      longint unsigned pulses;
      bit              next_pulse;
      span       = (beep_length == 0) ? 1 : beep_length;
      pulses     = (pulse_count == 0) ? 1 : pulse_count;
      outcome    = '0;
      next_pulse = 1'b0;
      if (trigger) begin
         alert_on   = 1'b1;
         pulse_no   = 0;
         in_gap     = 1'b0;
         seg_pos    = 0;
         tone_phase = '0;
      end
      if (!alert_on) begin
         return outcome;
      end
      outcome.playing = 1'b1;
      if (!in_gap) begin
         outcome.sample = shaped_tone(span);
         tone_phase     = tone_phase + 32'(phase_step);
         if (seg_pos + 1 >= span) begin
            seg_pos = 0;
            if (gap_length != 0) begin
               in_gap = 1'b1;
            end else begin
               next_pulse = 1'b1;
            end
         end else begin
            seg_pos++;
         end
      end else if (seg_pos + 1 >= gap_length) begin
         next_pulse = 1'b1;
      end else begin
         seg_pos++;
      end
      if (next_pulse) begin
         if (pulse_no + 1 >= pulses) begin
            outcome.last = 1'b1;
            alert_on     = 1'b0;
            pulse_no     = 0;
         end else begin
            pulse_no = (pulse_no + 1) % 16;
         end
         seg_pos    = 0;
         in_gap     = 1'b0;
         tone_phase = '0;
      end
      return outcome;
   endfunction

   function void set_register(logic [atbg_pkg::CSR_INDEX_BITS-1:0] index,
                              logic [atbg_pkg::CSR_DATA_BITS-1:0] value);
      case (index)
         atbg_pkg::CSR_VOLUME:      volume      = value[3:0];
         atbg_pkg::CSR_PHASE_STEP:  phase_step  = value[30:0];
         atbg_pkg::CSR_BEEP_LENGTH: beep_length = value[15:0];
         atbg_pkg::CSR_GAP_LENGTH:  gap_length  = value[15:0];
         atbg_pkg::CSR_PULSE_COUNT: pulse_count = value[3:0];
         default: ;
      endcase
   endfunction

   function void note_request(logic trigger);
      expected_samples.push_back(next_sample(trigger));
   endfunction

   function void check_sample(tone_result_type got);
      tone_result_type want;
      if (expected_samples.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected response: sample %0d playing %0b last %0b",
                     got.sample, got.playing, got.last);
         end
         return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample || got.playing !== want.playing ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response %0d: expected sample %0d playing %0b last %0b,",
                     checked, want.sample, want.playing, want.last,
                     " got sample %0d playing %0b last %0b",
                     got.sample, got.playing, got.last);
         end
      end
      checked++;
   endfunction
endclass

module alert_tone_burst_generator_tb;
   import atbg_pkg::*;

   localparam int unsigned HALF_PERIOD     = 4;
   localparam int unsigned MAX_WAIT        = 18;
   // Long receiver hold-off used to back the block up into its request side.
   localparam int unsigned LONG_HOLD       = 300;
   // Drain wait, well past the time that a ramp sample needs.
   localparam int unsigned DRAIN_CYCLES    = 40;
   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned RANDOM_REQUESTS = 1700;

   // How both sides pace a phase. The backlog mode keeps the sender busy
   // while the receiver holds off once for a long stretch.
   typedef enum logic [1:0] {
      PACE_BOTH,
      PACE_NONE,
      PACE_SENDER,
      PACE_BACKLOG
   } pace_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic                      req_trigger = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic signed [15:0]        rsp_sample;
   logic                      rsp_playing;
   logic                      rsp_last;
   logic                      csr_write   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_VOLUME;
   logic [CSR_DATA_BITS-1:0]  csr_data    = '0;

   alert_tone_checker tone_sb;
   pace_type          pace          = PACE_BOTH;
   bit                hold_off_once = 1'b0;
   int unsigned       requests_sent = 0;

   alert_tone_burst_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_trigger (req_trigger),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_playing (rsp_playing),
      .rsp_last    (rsp_last),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Offers one request and returns once the block has taken it. Inputs move
   // on the falling edge; the handshake is judged on the rising edge, where
   // the values seen are the ones the block itself samples. While the sender
   // idles the trigger wiggles, since the block must ignore it without valid.
   task automatic send_request(input logic trigger);
      int unsigned idle;
      idle = (pace == PACE_BOTH || pace == PACE_SENDER) ? $urandom_range(0, MAX_WAIT) : 0;
      repeat (idle) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_trigger <= 1'($urandom);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_trigger <= trigger;
      do @(posedge clock); while (req_stall !== 1'b0);
      tone_sb.note_request(trigger);
      requests_sent++;
   endtask

   // Sends count requests whose triggers are the low bits of the pattern,
   // least significant bit first.
   task automatic send_pattern(input logic [31:0] triggers, input int unsigned count);
      for (int i = 0; i < count; i++) begin
         send_request(triggers[i]);
      end
   endtask

   // Takes one response. The hold-off is drawn before the response shows up,
   // so stalls land on every stage of the block's work.
   task automatic take_response();
      int unsigned hold;
      hold = 0;
      if (hold_off_once) begin
         hold_off_once = 1'b0;
         hold          = LONG_HOLD;
      end else if (pace == PACE_BOTH || pace == PACE_BACKLOG) begin
         hold = $urandom_range(0, MAX_WAIT);
      end
      repeat (hold) begin
         @(negedge clock);
         rsp_stall <= 1'b1;
      end
      @(negedge clock);
      rsp_stall <= 1'b0;
      do @(posedge clock); while (rsp_valid !== 1'b1);
      tone_sb.check_sample(tone_result_type'({rsp_sample, rsp_playing, rsp_last}));
   endtask

   // One register write; the enable stays high so that back-to-back writes
   // need no second assignment in the same time step. close_writes drops it.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      tone_sb.set_register(index, value);
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Writes the selected registers. Bits above a narrow register's width
   // carry random junk, which the block has to drop.
   task automatic configure(input logic [3:0] vol, input logic [30:0] step,
                            input logic [15:0] beep, input logic [15:0] gap,
                            input logic [3:0] pulses, input logic [4:0] which);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom);
      if (which[0]) begin
         write_register(CSR_VOLUME, {junk[30:4], vol});
      end
      if (which[1]) begin
         write_register(CSR_PHASE_STEP, step);
      end
      if (which[2]) begin
         write_register(CSR_BEEP_LENGTH, {junk[30:16], beep});
      end
      if (which[3]) begin
         write_register(CSR_GAP_LENGTH, {junk[15:1], gap});
      end
      if (which[4]) begin
         write_register(CSR_PULSE_COUNT, {junk[26:0], pulses});
      end
      close_writes();
   endtask

   // Ends a phase: drop valid, let every predicted response arrive, then give
   // the block time to finish any internal work before registers change.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tone_sb.expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : response_side
      wait (reset === 1'b0);
      forever take_response();
   end

   // Ends the run if neither channel moves for too long, which covers a hung
   // block as well as responses that never come.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int unsigned first_random;
      int unsigned phase_no;
      int unsigned roll;
      int unsigned burst_len;
      logic [3:0]  vol;
      logic [3:0]  pulses;
      logic [30:0] step;
      logic [15:0] beep;
      logic [15:0] gap;
      logic [4:0]  which;
      bit          fresh;
      bit          noisy;
      tone_sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: an idle tick gives silence, a trigger starts the
      // alert on its own tick, and a later trigger restarts it at once.
      pace = PACE_BOTH;
      send_pattern(32'b10010, 5);
      settle();

      // Full volume with a quarter-turn step lands on the sine peaks, so the
      // product clips at both ends of the sample range. A zero gap and a zero
      // pulse count give one gapless pulse.
      configure(4'd15, 31'h4000_0000, 16'd16, 16'd0, 4'd0, '1);
      send_pattern(32'b1, 6);
      settle();

      // Zero beep length acts as one sample; two pulses with a short gap let
      // the last flag close the alert at the end of the second gap.
      configure(4'd0, 31'd0, 16'd0, 16'd3, 4'd2, '1);
      send_pattern(32'b1, 8);
      settle();

      // Indexes past the last register must not disturb anything.
      for (int spare = CSR_PULSE_COUNT + 1; spare < (1 << CSR_INDEX_BITS); spare++) begin
         write_register(CSR_INDEX_BITS'(spare), CSR_DATA_BITS'($urandom));
      end
      close_writes();

      // Shrinking the beep under a running pulse ends that pulse on the
      // current sample.
      configure(4'd11, 31'h7FFF_FFFF, 16'd40, 16'd2, 4'd15, '1);
      send_pattern(32'b1, 5);
      settle();
      write_register(CSR_BEEP_LENGTH, CSR_DATA_BITS'(3));
      close_writes();
      send_pattern(32'b0, 3);
      settle();

      // Random phases. Most start a fresh alert and then tick through it with
      // a rare retrigger; some carry on an alert across new settings, and a
      // few are pure trigger noise. Lengths stay short so that alerts finish,
      // with an occasional full-range length or gap.
      first_random = requests_sent;
      phase_no     = 0;
      while (requests_sent - first_random < RANDOM_REQUESTS) begin
         vol    = 4'($urandom);
         pulses = 4'($urandom);
         case ($urandom_range(0, 9))
            0:       step = '1;
            1:       step = '0;
            2, 3:    step = 31'h4000_0000;
            default: step = 31'($urandom);
         endcase
         roll = $urandom_range(0, 99);
         if (phase_no == 1 || roll < 3) begin
            beep = 16'hFFFF;
         end else if (roll < 8) begin
            beep = 16'($urandom);
         end else if (roll < 25) begin
            beep = 16'($urandom_range(49, 400));
         end else begin
            beep = 16'($urandom_range(0, 48));
         end
         roll = $urandom_range(0, 99);
         if (phase_no == 2) begin
            gap  = 16'hFFFF;
            beep = 16'($urandom_range(8, 24));
         end else if (roll < 3) begin
            gap = 16'hFFFF;
         end else if (roll < 6) begin
            gap = 16'($urandom);
         end else if (roll < 25) begin
            gap = 16'd0;
         end else begin
            gap = 16'($urandom_range(1, 12));
         end
         which = (phase_no == 0) ? 5'b11111 : 5'($urandom | $urandom);
         fresh = (phase_no == 0) || ($urandom_range(0, 4) != 0);
         noisy = ($urandom_range(0, 9) == 0);
         configure(vol, step, beep, gap, pulses, which);

         // The first random phase always backs the block up: the sender
         // streams without gaps while the receiver holds off.
         pace          = (phase_no == 0) ? PACE_BACKLOG : pace_type'($urandom_range(0, 3));
         hold_off_once = (pace == PACE_BACKLOG);
         burst_len     = $urandom_range(20, 80);
         for (int i = 0; i < burst_len; i++) begin
            if (noisy) begin
               send_request(1'($urandom));
            end else begin
               send_request((i == 0 && fresh) || ($urandom_range(0, 39) == 0));
            end
         end
         settle();
         phase_no++;
      end

      if (tone_sb.mismatches == 0 && tone_sb.expected_samples.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
